/* rtl/pbb_pkg.sv */
// ----------------------------------------------------------------------------
// pbb_pkg
// Shared constants and types of the page bitmap blitter: frame geometry,
// item function codes, register indexes and the memory operation word.
// ----------------------------------------------------------------------------
package pbb_pkg;

  // Frame geometry
  localparam int FRAME_COLS  = 128;
  localparam int FRAME_ROWS  = 64;
  localparam int STORE_DEPTH = FRAME_COLS * (FRAME_ROWS / 8);
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  // Wide working width for address arithmetic before range checks
  localparam int WIDE_W = 16;

  localparam logic [7:0]        COLS_B    = 8'(FRAME_COLS);
  localparam logic [7:0]        ROWS_B    = 8'(FRAME_ROWS);
  localparam logic [WIDE_W-1:0] DEPTH_W   = WIDE_W'(STORE_DEPTH);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_DEPTH - 1);

  // Item function codes
  localparam logic [1:0] FUNC_DRAW  = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;
  localparam logic [1:0] FUNC_NONE  = 2'd3;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_POS_X      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POS_Y      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BMP_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BMP_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SCROLL     = 3'd5;

  // Kind of framebuffer access
  typedef enum logic [1:0] {
    OP_RMW   = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2
  } op_kind_e;

  // One framebuffer operation, issued to the store unit
  typedef struct packed {
    logic              valid;
    op_kind_e          kind;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;   // OR value for a read-modify-write
    logic              zero;   // read beyond the store returns zero
  } op_t;

  // Store unit status back to the issue side
  typedef struct packed {
    logic take;   // head operation accepted this cycle
    logic busy;   // clearing sweep running
  } st_t;

endpackage

/* rtl/pbb_draw.sv */
// ----------------------------------------------------------------------------
// pbb_draw
// Configuration registers, blit column/page counters and clip geometry.
// Turns each accepted word into up to two framebuffer operations, held in
// two slots and issued to the store unit in order.
// ----------------------------------------------------------------------------
module pbb_draw import pbb_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [7:0]           cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           func_i,
  input  logic                 first_i,
  input  logic [7:0]           pixel_byte_i,
  input  logic [9:0]           read_addr_i,
  output op_t                  op_o,
  input  st_t                  st_i
);

  logic [7:0] pos_x_q, pos_y_q, width_q, height_q, scroll_q;
  logic       invert_q;
  logic [7:0] col_q, col_d;
  logic [4:0] page_q, page_d;
  op_t        slot_q [2];
  op_t        slot_d [2];

  logic       acc, left_none;
  logic [7:0] col_eff, col_inc;
  logic [4:0] page_eff;
  logic       draw_go, v_drop, ok;
  logic [7:0] y, bottom, top, next, xx, dtop, dbot, mask, pix;
  logic [2:0] po;
  logic [15:0] spread;
  logic [WIDE_W-1:0] wa0, wa1, wr_addr;
  logic       op0_v, op1_v, rd_oor;
  op_t        new0, new1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q  <= '0;
      pos_y_q  <= '0;
      width_q  <= '0;
      height_q <= '0;
      invert_q <= 1'b0;
      scroll_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_POS_X:      pos_x_q  <= cfg_wdata_i;
        REG_POS_Y:      pos_y_q  <= cfg_wdata_i;
        REG_BMP_WIDTH:  width_q  <= cfg_wdata_i;
        REG_BMP_HEIGHT: height_q <= cfg_wdata_i;
        REG_INVERT:     invert_q <= cfg_wdata_i[0];
        REG_SCROLL:     scroll_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Issue: head slot goes to the store; a new word enters once both slots
  // drain, so a two-byte draw holds the input until its second byte issues
  assign op_o      = slot_q[0].valid ? slot_q[0] : slot_q[1];
  assign left_none = (!slot_q[0].valid && !slot_q[1].valid) ||
                     (slot_q[0].valid != slot_q[1].valid && st_i.take);
  assign in_stall_o = !(left_none && !st_i.busy);
  assign acc        = in_valid_i && !in_stall_o;

  // Counter state as seen by this word
  assign col_eff  = first_i ? 8'd0 : col_q;
  assign page_eff = first_i ? 5'd0 : page_q;
  assign col_inc  = col_eff + 8'd1;
  assign draw_go  = acc && (func_i == FUNC_DRAW) && (width_q != 8'd0) &&
                    (page_eff < height_q[7:3]);

  always_comb begin
    col_d  = col_q;
    page_d = page_q;
    if (draw_go) begin
      if (col_inc >= width_q) begin
        col_d  = 8'd0;
        page_d = page_eff + 5'd1;
      end else begin
        col_d  = col_inc;
        page_d = page_eff;
      end
    end else if (acc && (func_i == FUNC_DRAW) && first_i) begin
      col_d  = 8'd0;
      page_d = 5'd0;
    end
  end

  // Vertical geometry, all 8-bit wrapping
  assign y      = pos_y_q - scroll_q;
  assign po     = y[2:0];
  assign bottom = pos_y_q + height_q;
  assign top    = {page_eff, 3'b000} + y;
  assign next   = top + 8'd8;
  assign dtop   = pos_y_q - top;
  assign dbot   = next - bottom;
  assign v_drop = (scroll_q != 8'd0) &&
                  ((next < pos_y_q) || (next > ROWS_B) || (top > bottom));

  // Clip mask at the top and bottom edges, only while scrolled
  always_comb begin
    mask = 8'hFF;
    if (scroll_q != 8'd0) begin
      if (top < pos_y_q) begin
        mask = (dtop >= 8'd8) ? 8'd0 : (8'hFF << dtop[2:0]);
      end else if (next > bottom) begin
        mask = (dbot >= 8'd8) ? 8'd0 : (8'hFF >> dbot[2:0]);
      end
    end
  end

  assign xx  = pos_x_q + col_eff;
  assign ok  = draw_go && !v_drop && (xx < COLS_B);
  assign pix = (invert_q ? ~pixel_byte_i : pixel_byte_i) & mask;

  // Low byte lands in the top page, high byte spills into the next page
  assign spread = {8'd0, pix} << po;

  assign wa0   = WIDE_W'(top[7:3])  * WIDE_W'(FRAME_COLS) + WIDE_W'(xx);
  assign wa1   = WIDE_W'(next[7:3]) * WIDE_W'(FRAME_COLS) + WIDE_W'(xx);
  assign op0_v = ok && (top < ROWS_B) && (wa0 < DEPTH_W);
  assign op1_v = ok && (next < ROWS_B) && (po != 3'd0) && (wa1 < DEPTH_W);

  assign wr_addr = WIDE_W'(read_addr_i);
  assign rd_oor  = wr_addr >= DEPTH_W;

  // Operations for the incoming word; a lone spill byte moves to slot 0
  always_comb begin
    new0 = '0;
    new1 = '0;
    unique case (func_i)
      FUNC_DRAW: begin
        if (op0_v) begin
          new0 = '{valid: 1'b1, kind: OP_RMW, addr: wa0[ADDR_W-1:0],
                   data: spread[7:0], zero: 1'b0};
          new1 = '{valid: op1_v, kind: OP_RMW, addr: wa1[ADDR_W-1:0],
                   data: spread[15:8], zero: 1'b0};
        end else begin
          new0 = '{valid: op1_v, kind: OP_RMW, addr: wa1[ADDR_W-1:0],
                   data: spread[15:8], zero: 1'b0};
        end
      end
      FUNC_READ: begin
        new0 = '{valid: 1'b1, kind: OP_READ,
                 addr: rd_oor ? '0 : wr_addr[ADDR_W-1:0],
                 data: 8'd0, zero: rd_oor};
      end
      FUNC_CLEAR: begin
        new0 = '{valid: 1'b1, kind: OP_CLEAR, addr: '0, data: 8'd0, zero: 1'b0};
      end
      FUNC_NONE: ;
    endcase
  end

  // Slot update
  always_comb begin
    slot_d[0] = slot_q[0];
    slot_d[1] = slot_q[1];
    if (acc) begin
      slot_d[0] = new0;
      slot_d[1] = new1;
    end else if (st_i.take) begin
      if (slot_q[0].valid) begin
        slot_d[0].valid = 1'b0;
      end else begin
        slot_d[1].valid = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      page_q    <= '0;
      slot_q[0] <= '0;
      slot_q[1] <= '0;
    end else begin
      col_q     <= col_d;
      page_q    <= page_d;
      slot_q[0] <= slot_d[0];
      slot_q[1] <= slot_d[1];
    end
  end

endmodule

/* rtl/pbb_store.sv */
// ----------------------------------------------------------------------------
// pbb_store
// Framebuffer memory with one write and one read port, a read-modify-write
// stage with forwarding of the previous write, a clearing sweep and a
// two-word output queue for read results.
// ----------------------------------------------------------------------------
module pbb_store import pbb_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  op_t        op_i,
  output st_t        st_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] read_data_o
);

  logic [7:0]        mem [STORE_DEPTH];
  logic [7:0]        rd_data_q;

  logic              sweep_q, sweep_d;
  logic [ADDR_W-1:0] sweep_cnt_q, sweep_cnt_d;

  logic              w_valid_q;
  op_kind_e          w_kind_q;
  logic [ADDR_W-1:0] w_addr_q;
  logic [7:0]        w_data_q;
  logic              w_zero_q;

  logic              fwd_valid_q;
  logic [ADDR_W-1:0] fwd_addr_q;
  logic [7:0]        fwd_data_q;

  logic [7:0]        q_data_q [2];
  logic              q_wptr_q, q_rptr_q;
  logic [1:0]        q_cnt_q;

  logic              rdy, take, room, push, pop, wr;
  logic [2:0]        q_next;
  logic [7:0]        cur, upd;

  // Output queue occupancy after this cycle; a read may issue only when
  // its result is sure to find a free entry
  assign pop    = (q_cnt_q != 2'd0) && !out_stall_i;
  assign push   = w_valid_q && (w_kind_q == OP_READ);
  assign q_next = 3'(q_cnt_q) + 3'(push) - 3'(pop);
  assign room   = q_next <= 3'd1;

  // Acceptance of the head operation
  always_comb begin
    unique case (op_i.kind)
      OP_RMW:   rdy = 1'b1;
      OP_READ:  rdy = room;
      OP_CLEAR: rdy = !w_valid_q;
      default:  rdy = 1'b0;
    endcase
  end

  assign take      = op_i.valid && !sweep_q && rdy;
  assign st_o.take = take;
  assign st_o.busy = sweep_q;

  // Modify stage: memory data, or the write of the cycle before
  assign cur = (fwd_valid_q && (fwd_addr_q == w_addr_q)) ? fwd_data_q : rd_data_q;
  assign upd = cur | w_data_q;
  assign wr  = w_valid_q && (w_kind_q == OP_RMW);

  // Memory: sweep writes zero, otherwise the modify stage writes back
  always_ff @(posedge clk_i) begin
    if (sweep_q) begin
      mem[sweep_cnt_q] <= 8'd0;
    end else if (wr) begin
      mem[w_addr_q] <= upd;
    end
    if (take) begin
      rd_data_q <= mem[op_i.addr];
    end
  end

  // Clearing sweep, run after reset and for each clear word
  always_comb begin
    sweep_d     = sweep_q;
    sweep_cnt_d = sweep_cnt_q;
    if (sweep_q) begin
      sweep_cnt_d = sweep_cnt_q + ADDR_W'(1);
      if (sweep_cnt_q == LAST_ADDR) begin
        sweep_d     = 1'b0;
        sweep_cnt_d = '0;
      end
    end else if (take && (op_i.kind == OP_CLEAR)) begin
      sweep_d     = 1'b1;
      sweep_cnt_d = '0;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q     <= 1'b1;
      sweep_cnt_q <= '0;
      w_valid_q   <= 1'b0;
      fwd_valid_q <= 1'b0;
      q_wptr_q    <= 1'b0;
      q_rptr_q    <= 1'b0;
      q_cnt_q     <= 2'd0;
    end else begin
      sweep_q     <= sweep_d;
      sweep_cnt_q <= sweep_cnt_d;
      w_valid_q   <= take && (op_i.kind != OP_CLEAR);
      fwd_valid_q <= wr;
      if (push) q_wptr_q <= !q_wptr_q;
      if (pop)  q_rptr_q <= !q_rptr_q;
      q_cnt_q     <= q_next[1:0];
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (take) begin
      w_kind_q <= op_i.kind;
      w_addr_q <= op_i.addr;
      w_data_q <= op_i.data;
      w_zero_q <= op_i.zero;
    end
    if (wr) begin
      fwd_addr_q <= w_addr_q;
      fwd_data_q <= upd;
    end
    if (push) begin
      q_data_q[q_wptr_q] <= w_zero_q ? 8'd0 : cur;
    end
  end

  assign out_valid_o = q_cnt_q != 2'd0;
  assign read_data_o = q_data_q[q_rptr_q];

`ifndef SYNTHESIS
  a_queue_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |-> (q_cnt_q != 2'd2))
    else $error("read result pushed into a full output queue");

  a_no_take_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sweep_q |-> !take)
    else $error("operation taken while the store is being cleared");

  a_clear_after_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && (op_i.kind == OP_CLEAR)) |-> !w_valid_q)
    else $error("clear started with a write-back still pending");

  a_sweep_ends_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(sweep_q) |-> (!fwd_valid_q && !w_valid_q))
    else $error("stale forwarding or modify stage across a clear");
`endif

endmodule

/* rtl/page_bitmap_blitter_core.sv */
// ----------------------------------------------------------------------------
// page_bitmap_blitter_core
// Blits page-organised monochrome bitmap bytes into a framebuffer of
// vertical 8-pixel bytes, serves byte reads and clears the store.
//
//   channel   direction  handshake                 payload
//   in        sink       in_valid_i / in_stall_o   func, first, pixel_byte,
//                                                  read_addr
//   out       source     out_valid_o / out_stall_i read_data
//   cfg       sink       cfg_we_i                  cfg_idx_i, cfg_wdata_i
//
// A draw word holds the input until the store has taken each framebuffer
// byte it touches (1 or 2); the single write port of the store takes them
// one at a time.
// Reads issue only while the two-word output queue has room, so a stalled
// output throttles reads and any words queued behind them.
// A clear word waits for the write-back stage to drain; it, and reset, then
// run a sweep over all STORE_DEPTH (1024) addresses, accepting no word.
// ----------------------------------------------------------------------------
module page_bitmap_blitter_core import pbb_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [7:0]           cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           func_i,
  input  logic                 first_i,
  input  logic [7:0]           pixel_byte_i,
  input  logic [9:0]           read_addr_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [7:0]           read_data_o
);

  op_t op;
  st_t st;

  // Counters, geometry and operation issue
  pbb_draw u_draw (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .func_i       (func_i),
    .first_i      (first_i),
    .pixel_byte_i (pixel_byte_i),
    .read_addr_i  (read_addr_i),
    .op_o         (op),
    .st_i         (st)
  );

  // Framebuffer memory and read results
  pbb_store u_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_i        (op),
    .st_o        (st),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .read_data_o (read_data_o)
  );

endmodule

/* tb/sv/blit_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blit_checker
// Watches the configuration port and both word channels of the page bitmap
// blitter, keeps its own copy of the framebuffer, the position counters and
// the registers, and compares every read_data word with the byte it predicts.
// ----------------------------------------------------------------------------
module blit_checker import pbb_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [7:0]           cfg_wdata_i,
  input  logic                 in_valid_i,
  input  logic                 in_stall_o,
  input  logic [1:0]           func_i,
  input  logic                 first_i,
  input  logic [7:0]           pixel_byte_i,
  input  logic [9:0]           read_addr_i,
  input  logic                 out_valid_o,
  input  logic                 out_stall_i,
  input  logic [7:0]           read_data_o,
  output int                   fail_count,
  output int                   reads_waiting
);

  // Shadow framebuffer, counters and registers
  logic [7:0] frame_img [STORE_DEPTH];
  logic [7:0] col_cnt;
  logic [4:0] page_cnt;
  logic [7:0] pos_x, pos_y, bmp_w, bmp_h, scroll;
  logic       invert;

  // Bytes that reads have been issued for, oldest first
  logic [7:0] read_bytes_due [$];

  initial fail_count = 0;

  task automatic report_mismatch(input string what, input logic [7:0] want,
                                 input logic [7:0] got);
    $display("%0t ns blit_checker: %s, wanted %02h, got %02h", $time, what, want, got);
    fail_count++;
  endtask

  function automatic void or_into_frame(int unsigned addr, logic [7:0] v);
    if (addr < STORE_DEPTH)
      frame_img[addr] = frame_img[addr] | v;
  endfunction

  // One bitmap byte at the current counters: clip, mask, invert, then OR in
  function automatic void paint_byte(logic [7:0] data);
    logic [7:0] y, bottom, top, nxt, mask, xx, pix, d;
    logic [2:0] po;
    y      = pos_y - scroll;
    po     = y[2:0];
    bottom = pos_y + bmp_h;
    top    = {page_cnt, 3'b000} + y;
    nxt    = top + 8'd8;
    mask   = 8'hFF;
    // vertical clipping only applies while scrolled
    if (scroll != 8'd0) begin
      if (nxt < pos_y || nxt > ROWS_B || top > bottom)
        return;
      if (top < pos_y) begin
        d    = pos_y - top;
        mask = (d >= 8'd8) ? 8'h00 : 8'(8'hFF << d);
      end else if (nxt > bottom) begin
        d    = nxt - bottom;
        mask = (d >= 8'd8) ? 8'h00 : 8'(8'hFF >> d);
      end
    end
    xx = pos_x + col_cnt;
    if (xx >= COLS_B)
      return;
    pix = (invert ? ~data : data) & mask;
    if (po == 3'd0 && top < ROWS_B) begin
      or_into_frame((top >> 3) * FRAME_COLS + xx, pix);
    end else begin
      if (top < ROWS_B)
        or_into_frame((top >> 3) * FRAME_COLS + xx, 8'(pix << po));
      if (nxt < ROWS_B)
        or_into_frame((nxt >> 3) * FRAME_COLS + xx, 8'(pix >> (4'd8 - po)));
    end
  endfunction

  // Effect of one accepted input word
  function automatic void blit_step(logic [1:0] f, logic fst, logic [7:0] data,
                                    logic [9:0] addr);
    case (f)
      FUNC_DRAW: begin
        if (fst) begin
          col_cnt  = 8'd0;
          page_cnt = 5'd0;
        end
        // counters past the end of the bitmap: byte ignored, counters hold
        if (bmp_w != 8'd0 && {3'b000, page_cnt} < (bmp_h >> 3)) begin
          paint_byte(data);
          col_cnt = col_cnt + 8'd1;
          if (col_cnt >= bmp_w) begin
            col_cnt  = 8'd0;
            page_cnt = page_cnt + 5'd1;
          end
        end
      end
      FUNC_READ:  read_bytes_due.push_back(addr < STORE_DEPTH ? frame_img[addr] : 8'h00);
      FUNC_CLEAR: foreach (frame_img[i]) frame_img[i] = 8'h00;
      default: ;
    endcase
  endfunction

  // Channel monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (frame_img[i]) frame_img[i] = 8'h00;
      col_cnt  = 8'd0;
      page_cnt = 5'd0;
      pos_x    = 8'd0;
      pos_y    = 8'd0;
      bmp_w    = 8'd0;
      bmp_h    = 8'd0;
      invert   = 1'b0;
      scroll   = 8'd0;
      read_bytes_due.delete();
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (read_bytes_due.size() == 0)
          report_mismatch("read_data word with no read outstanding", 8'hxx, read_data_o);
        else if (read_data_o !== read_bytes_due[0])
          report_mismatch("read_data", read_bytes_due.pop_front(), read_data_o);
        else
          void'(read_bytes_due.pop_front());
      end
      if (in_valid_i && !in_stall_o)
        blit_step(func_i, first_i, pixel_byte_i, read_addr_i);
      // a register write applies from the next word on
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_POS_X:      pos_x  = cfg_wdata_i;
          REG_POS_Y:      pos_y  = cfg_wdata_i;
          REG_BMP_WIDTH:  bmp_w  = cfg_wdata_i;
          REG_BMP_HEIGHT: bmp_h  = cfg_wdata_i;
          REG_INVERT:     invert = cfg_wdata_i[0];
          REG_SCROLL:     scroll = cfg_wdata_i;
          default: ;
        endcase
      end
    end
    reads_waiting = read_bytes_due.size();
  end

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the page bitmap blitter with directed words and then with random
// blits under changing position, size, invert and scroll settings, with
// random gaps on the input and stalls on the output; blit_checker predicts
// and compares every read_data word.
// ----------------------------------------------------------------------------
module testbench;
  import pbb_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PHASE_WORDS    = 150;
  localparam int SETTLE_CYCLES  = 20;

  logic                 clk_i        = 1'b0;
  logic                 rst_ni       = 1'b0;
  logic                 cfg_we_i     = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i    = REG_POS_X;
  logic [7:0]           cfg_wdata_i  = 8'd0;
  logic                 in_valid_i   = 1'b0;
  logic                 in_stall_o;
  logic [1:0]           func_i       = FUNC_NONE;
  logic                 first_i      = 1'b0;
  logic [7:0]           pixel_byte_i = 8'd0;
  logic [9:0]           read_addr_i  = 10'd0;
  logic                 out_valid_o;
  logic                 out_stall_i  = 1'b0;
  logic [7:0]           read_data_o;

  int fail_count;
  int reads_waiting;
  int send_gap_pct = 10;
  int recv_gap_pct = 45;
  int words_sent   = 0;
  int quiet_cycles = 0;

  // Current blit settings, used to aim reads at drawn areas
  logic [7:0] cur_x, cur_w, cur_h;

  page_bitmap_blitter_core DUT (.*);

  blit_checker u_blit_check (.*);

  // 50 MHz clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Receiver stalls at random
  always @(negedge clk_i)
    out_stall_i <= ($urandom_range(99) < recv_gap_pct);

  // Watchdog: too long with no word moving on either channel
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("testbench: FAIL");
        $finish;
      end
    end
  end

  // One input word, with random gaps ahead of it
  task automatic send_word(input logic [1:0] f, input logic fst, input logic [7:0] data,
                           input logic [9:0] addr);
    while ($urandom_range(99) < send_gap_pct) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i   <= 1'b1;
    func_i       <= f;
    first_i      <= fst;
    pixel_byte_i <= data;
    read_addr_i  <= addr;
    do @(posedge clk_i); while (in_stall_o);
    words_sent++;
  endtask

  // Hold off until every read has returned and the store has gone quiet
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (reads_waiting != 0 || in_stall_o) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
  endtask

  task automatic set_config(input logic [7:0] px, input logic [7:0] py,
                            input logic [7:0] w, input logic [7:0] h,
                            input logic [7:0] inv, input logic [7:0] scr);
    settle();
    write_reg(REG_POS_X, px);
    write_reg(REG_POS_Y, py);
    write_reg(REG_BMP_WIDTH, w);
    write_reg(REG_BMP_HEIGHT, h);
    write_reg(REG_INVERT, inv);
    write_reg(REG_SCROLL, scr);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    cur_x = px;
    cur_w = w;
    cur_h = h;
  endtask

  function automatic logic [7:0] pick_extreme();
    case ($urandom_range(2))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // Mostly within the current blit's columns, sometimes anywhere
  function automatic logic [9:0] pick_addr();
    if ($urandom_range(99) < 40)
      return 10'($urandom_range(STORE_DEPTH - 1));
    return {3'($urandom_range(7)), 7'(cur_x + 8'($urandom_range(cur_w)))};
  endfunction

  task automatic random_config();
    logic [7:0] px, py, w, h, scr;
    if ($urandom_range(99) < 75) begin
      px  = 8'($urandom_range(140));
      py  = 8'($urandom_range(70));
      w   = 8'($urandom_range(1, 16));
      h   = 8'($urandom_range(8, 32));
      scr = $urandom_range(1) ? 8'd0 : 8'($urandom_range(1, 24));
    end else begin
      px  = pick_extreme();
      py  = pick_extreme();
      w   = pick_extreme();
      h   = pick_extreme();
      scr = pick_extreme();
    end
    set_config(px, py, w, h, 8'($urandom), scr);
  endtask

  // A blit with random bytes, sprinkled with reads, no-ops and restarts,
  // two words longer than the bitmap (capped at 48), then a few reads back
  task automatic run_blit();
    int n_draw;
    int r;
    n_draw = int'(cur_w) * int'(cur_h >> 3);
    if (n_draw > 48) n_draw = 48;
    for (int k = 0; k < n_draw + 2; k++) begin
      r = $urandom_range(99);
      if (r < 12)
        send_word(FUNC_READ, 1'($urandom), 8'($urandom), pick_addr());
      else if (r < 15)
        send_word(FUNC_NONE, 1'($urandom), 8'($urandom), 10'($urandom));
      else if (r < 17)
        send_word(FUNC_DRAW, 1'b1, 8'($urandom), 10'($urandom));
      else
        send_word(FUNC_DRAW, k == 0, 8'($urandom), 10'($urandom));
    end
    repeat (6) send_word(FUNC_READ, 1'($urandom), 8'($urandom), pick_addr());
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Two columns by two pages at the origin, then one byte past the end
    set_config(8'd0, 8'd0, 8'd2, 8'd16, 8'd0, 8'd0);
    send_word(FUNC_DRAW, 1'b1, 8'hFF, 10'd0);
    send_word(FUNC_DRAW, 1'b0, 8'h00, 10'h3FF);
    send_word(FUNC_DRAW, 1'b0, 8'h81, 10'd0);
    send_word(FUNC_DRAW, 1'b0, 8'h7E, 10'd0);
    send_word(FUNC_DRAW, 1'b0, 8'hA5, 10'd0);
    send_word(FUNC_READ, 1'b1, 8'h00, 10'd0);
    send_word(FUNC_READ, 1'b0, 8'hFF, 10'd129);
    send_word(FUNC_READ, 1'b0, 8'h00, 10'h3FF);
    send_word(FUNC_NONE, 1'b1, 8'hFF, 10'h3FF);
    send_word(FUNC_CLEAR, 1'b1, 8'h00, 10'd0);
    send_word(FUNC_READ, 1'b0, 8'h00, 10'd0);

    // Right frame edge, unaligned row, inverted: columns past the edge drop
    set_config(8'd127, 8'd3, 8'd3, 8'd8, 8'd1, 8'd0);
    send_word(FUNC_DRAW, 1'b1, 8'h0F, 10'd0);
    send_word(FUNC_DRAW, 1'b0, 8'hF0, 10'd0);
    send_word(FUNC_DRAW, 1'b0, 8'hAA, 10'd0);
    send_word(FUNC_READ, 1'b0, 8'h00, 10'd127);
    send_word(FUNC_READ, 1'b0, 8'h00, 10'd255);

    // Scrolled: top clip mask and a split across pages
    set_config(8'd5, 8'd12, 8'd1, 8'd16, 8'd0, 8'd3);
    send_word(FUNC_DRAW, 1'b1, 8'hFF, 10'd0);
    send_word(FUNC_DRAW, 1'b0, 8'hFF, 10'd0);
    send_word(FUNC_READ, 1'b0, 8'h00, 10'd133);
    send_word(FUNC_READ, 1'b0, 8'h00, 10'd261);
    send_word(FUNC_READ, 1'b0, 8'h00, 10'd389);

    // Random blits under three idling patterns
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0:       begin send_gap_pct = 10; recv_gap_pct = 45; end
        1:       begin send_gap_pct = 45; recv_gap_pct = 10; end
        default: begin send_gap_pct = 0;  recv_gap_pct = 0;  end
      endcase
      send_word(FUNC_CLEAR, 1'($urandom), 8'($urandom), 10'($urandom));
      while (words_sent < 21 + PHASE_WORDS * (phase + 1)) begin
        random_config();
        run_blit();
      end
    end

    // Drain and let the store go quiet
    settle();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (fail_count == 0)
      $display("testbench: PASS");
    else
      $display("testbench: FAIL");
    $finish;
  end

endmodule

/* sim.f */
rtl/pbb_pkg.sv
rtl/pbb_draw.sv
rtl/pbb_store.sv
rtl/page_bitmap_blitter_core.sv
tb/sv/blit_checker.sv
tb/sv/testbench.sv
